// ===== hdl/multi_slot_tick_scheduler_defines.svh =====
// Assertion macros shared by the scheduler's checker.
// No dependencies; included by the checker file only.
`ifndef MULTI_SLOT_TICK_SCHEDULER_DEFINES_SVH
`define MULTI_SLOT_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mst_pkg.sv =====
// Types and constants of the multi-slot tick scheduler.
// No dependencies; used by the interfaces, all modules and the checker.
package mst_pkg;

	localparam int OP_W     = 3;
	localparam int SLOT_W   = 4;
	localparam int PERIOD_W = 16;
	localparam int FIRE_W   = 8;
	localparam int TICK_W   = 32;

	typedef enum logic [OP_W-1:0] {
		OP_TICK       = 3'd0,
		OP_SCAN       = 3'd1,
		OP_ALLOC      = 3'd2,
		OP_START      = 3'd3,
		OP_STOP       = 3'd4,
		OP_SET_PERIOD = 3'd5,
		OP_GET_PERIOD = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN_RD,
		ST_SCAN_WB,
		ST_GET_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [FIRE_W-1:0]   fire_mask;
		logic [SLOT_W-1:0]   slot_out;
		logic [PERIOD_W-1:0] period_out;
		logic                ok;
	} res_t;

	typedef struct packed {
		logic rd_en;
		logic nf_we;
		logic per_we;
	} mem_ctl_t;

endpackage

// ===== hdl/mst_if.sv =====
// Handshake interfaces for the scheduler's request and result channels.
// Depends on mst_pkg for the field widths.
interface mst_req_if import mst_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [SLOT_W-1:0]   slot;
	logic [PERIOD_W-1:0] period;

	modport source (output valid, op, slot, period, input ready);
	modport sink (input valid, op, slot, period, output ready);
endinterface

interface mst_rsp_if import mst_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FIRE_W-1:0]   fire_mask;
	logic [SLOT_W-1:0]   slot_out;
	logic [PERIOD_W-1:0] period_out;
	logic                ok;

	modport source (output valid, fire_mask, slot_out, period_out, ok, input ready);
	modport sink (input valid, fire_mask, slot_out, period_out, ok, output ready);
endinterface

// ===== hdl/mst_slot_mem.sv =====
// Per-slot storage: next-fire tick and period, one synchronous read port.
// Depends on mst_pkg for widths and the memory control struct.
module mst_slot_mem import mst_pkg::*; #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic                clk,
	input  mem_ctl_t            ctl,
	input  logic [AW-1:0]       rd_addr,
	input  logic [AW-1:0]       wr_addr,
	input  logic [TICK_W-1:0]   nf_wdata,
	input  logic [PERIOD_W-1:0] per_wdata,
	output logic [TICK_W-1:0]   nf_rdata,
	output logic [PERIOD_W-1:0] per_rdata
);

	logic [TICK_W-1:0]   nf_mem  [DEPTH];
	logic [PERIOD_W-1:0] per_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.nf_we) begin
			nf_mem[wr_addr] <= nf_wdata;
		end
		if (ctl.rd_en) begin
			nf_rdata <= nf_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.per_we) begin
			per_mem[wr_addr] <= per_wdata;
		end
		if (ctl.rd_en) begin
			per_rdata <= per_mem[rd_addr];
		end
	end

endmodule

// ===== hdl/mst_ctrl.sv =====
// Sequencer of the scheduler: op decode, tick counter, slot flags and the
// slot-by-slot scan over the slot memory. Depends on mst_pkg.
module mst_ctrl import mst_pkg::*; #(
	parameter int SLOTS = 8,
	parameter int AW    = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     in_op,
	input  logic [SLOT_W-1:0]   in_slot,
	input  logic [PERIOD_W-1:0] in_period,
	output logic                res_valid,
	input  logic                res_ready,
	output res_t                res,
	output mem_ctl_t            mem_ctl,
	output logic [AW-1:0]       rd_addr,
	output logic [AW-1:0]       wr_addr,
	output logic [TICK_W-1:0]   nf_wdata,
	output logic [PERIOD_W-1:0] per_wdata,
	input  logic [TICK_W-1:0]   nf_rdata,
	input  logic [PERIOD_W-1:0] per_rdata
);

	state_t              state_q, state_d;
	logic [OP_W-1:0]     op_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [PERIOD_W-1:0] period_q;
	logic [TICK_W-1:0]   tick_q;
	logic [SLOTS-1:0]    used_q;
	logic [SLOTS-1:0]    run_q;
	logic [AW-1:0]       idx_q;
	res_t                res_q;

	logic          slot_ok;
	logic [AW-1:0] slot_a;
	logic          pick_found;
	logic [AW-1:0] pick_a;
	logic          fire;
	logic          last_idx;
	res_t          res_exec;

	assign slot_a  = slot_q[AW-1:0];
	assign slot_ok = ({1'b0, slot_q} < (SLOT_W+1)'(SLOTS)) && used_q[slot_a];

	// Highest free slot wins.
	always_comb begin
		pick_found = 1'b0;
		pick_a     = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!used_q[i]) begin
				pick_found = 1'b1;
				pick_a     = AW'(i);
			end
		end
	end

	assign fire     = used_q[idx_q] && run_q[idx_q] && (tick_q >= nf_rdata);
	assign last_idx = (idx_q == AW'(SLOTS - 1));

	// Result of the execute cycle; scan and get period fill in the rest later.
	always_comb begin
		res_exec = '0;
		case (op_t'(op_q)) inside
			OP_TICK, OP_SCAN: res_exec.ok = 1'b1;
			OP_ALLOC: begin
				res_exec.ok       = pick_found;
				res_exec.slot_out = pick_found ? SLOT_W'(pick_a) : '0;
			end
			OP_START, OP_STOP, OP_SET_PERIOD: res_exec.ok = slot_ok;
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (op_t'(op_q))
					OP_SCAN:       state_d = ST_SCAN_RD;
					OP_GET_PERIOD: state_d = slot_ok ? ST_GET_WAIT : ST_DONE;
					default:       state_d = ST_DONE;
				endcase
			end
			ST_SCAN_RD:  state_d = ST_SCAN_WB;
			ST_SCAN_WB:  state_d = last_idx ? ST_DONE : ST_SCAN_RD;
			ST_GET_WAIT: state_d = ST_DONE;
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		res_valid = (state_q == ST_DONE);
		mem_ctl   = '0;
		rd_addr   = (state_q == ST_EXEC) ? slot_a : idx_q;
		wr_addr   = slot_a;
		nf_wdata  = '0;
		per_wdata = period_q;
		unique case (state_q)
			ST_EXEC: begin
				unique case (op_t'(op_q))
					OP_ALLOC: begin
						mem_ctl.per_we = pick_found;
						wr_addr        = pick_a;
					end
					OP_START:      mem_ctl.nf_we  = slot_ok;
					OP_SET_PERIOD: mem_ctl.per_we = slot_ok;
					OP_GET_PERIOD: mem_ctl.rd_en  = slot_ok;
					default: ;
				endcase
			end
			ST_SCAN_RD: mem_ctl.rd_en = 1'b1;
			ST_SCAN_WB: begin
				mem_ctl.nf_we = fire;
				wr_addr       = idx_q;
				nf_wdata      = nf_rdata + TICK_W'(per_rdata);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_q  <= '0;
			used_q  <= '0;
			run_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				idx_q <= '0;
				case (op_t'(op_q))
					OP_TICK: tick_q <= tick_q + 1'b1;
					OP_ALLOC: begin
						if (pick_found) begin
							used_q[pick_a] <= 1'b1;
							run_q[pick_a]  <= 1'b0;
						end
					end
					OP_START: begin
						if (slot_ok) begin
							run_q[slot_a] <= 1'b1;
						end
					end
					OP_STOP: begin
						if (slot_ok) begin
							run_q[slot_a] <= 1'b0;
						end
					end
					default: ;
				endcase
			end else if (state_q == ST_SCAN_WB && !last_idx) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q     <= in_op;
			slot_q   <= in_slot;
			period_q <= in_period;
		end
		case (state_q)
			ST_EXEC: res_q <= res_exec;
			ST_SCAN_WB: begin
				// Slots beyond the mask width still advance but are not reported.
				for (int b = 0; b < FIRE_W; b++) begin
					if (fire && int'(idx_q) == b) begin
						res_q.fire_mask[b] <= 1'b1;
					end
				end
			end
			ST_GET_WAIT: begin
				res_q.period_out <= per_rdata;
				res_q.ok         <= 1'b1;
			end
			default: ;
		endcase
	end

	assign res = res_q;

endmodule

// ===== hdl/multi_slot_tick_scheduler.sv =====
// Channel   Dir  Fields                                   Beat taken when
// req       in   op[2:0] slot[3:0] period[15:0]           req.valid && req.ready
// rsp       out  fire_mask[7:0] slot_out[3:0]             rsp.valid && rsp.ready
//                period_out[15:0] ok
//
// One request is processed at a time. Tick, allocate, start, stop, set period,
// the unused op code and a get period on an invalid slot go from the execute
// state straight to the done state, a get period on an allocated slot passes a
// wait state for the memory read, and scan alternates a read and a write-back
// state per slot because the slot memory has a single read port. Reset is
// asynchronous and active low; it clears the tick counter and the allocated
// and running flags, while the slot memory holds no reset value and its words
// are only used for slots that were written before.
// A stalled result sits in the output register while the next request beat
// is already taken; that request waits in its final state until the register
// frees up.
//
// Top level of the multi-slot tick scheduler. Depends on mst_pkg, mst_if,
// mst_slot_mem and mst_ctrl.
module multi_slot_tick_scheduler import mst_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	mst_req_if.sink       req,
	mst_rsp_if.source     rsp
);

	// Slot address width; a single slot still gets a one-bit address.
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	mem_ctl_t            mem_ctl;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [TICK_W-1:0]   nf_wdata;
	logic [PERIOD_W-1:0] per_wdata;
	logic [TICK_W-1:0]   nf_rdata;
	logic [PERIOD_W-1:0] per_rdata;

	logic res_valid;
	logic res_ready;
	res_t res;

	logic out_valid_q;
	res_t out_q;

	// The sequencer owns the tick counter, the flags and the scan order; all
	// per-slot words live in the memory and are read the cycle before their use.
	mst_ctrl #(
		.SLOTS (SLOTS),
		.AW    (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_op     (req.op),
		.in_slot   (req.slot),
		.in_period (req.period),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_ctl   (mem_ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.nf_wdata  (nf_wdata),
		.per_wdata (per_wdata),
		.nf_rdata  (nf_rdata),
		.per_rdata (per_rdata)
	);

	mst_slot_mem #(
		.DEPTH (SLOTS),
		.AW    (AW)
	) u_mem (
		.clk       (clk),
		.ctl       (mem_ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.nf_wdata  (nf_wdata),
		.per_wdata (per_wdata),
		.nf_rdata  (nf_rdata),
		.per_rdata (per_rdata)
	);

	// Output register: loads whenever it is empty or its beat leaves now.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.fire_mask  = out_q.fire_mask;
	assign rsp.slot_out   = out_q.slot_out;
	assign rsp.period_out = out_q.period_out;
	assign rsp.ok         = out_q.ok;

endmodule

// ===== hdl/mst_checker.sv =====
// Port-level checks for the multi-slot tick scheduler, bound to its top level.
// Depends on mst_pkg and multi_slot_tick_scheduler_defines.svh.
`include "multi_slot_tick_scheduler_defines.svh"

module mst_checker import mst_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [FIRE_W-1:0]   fire_mask,
	input logic [SLOT_W-1:0]   slot_out,
	input logic [PERIOD_W-1:0] period_out,
	input logic                ok
);

	// A held result keeps its payload until it is taken.
	`MST_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable({fire_mask, slot_out, period_out, ok}), "result changed while stalled")

	// Only one request is in flight: ready drops right after a request beat.
	`MST_ASSERT_NXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while another is in flight")

	// A nonzero slot index only comes from a successful allocate.
	`MST_ASSERT_IMP(a_slot_out_ok, clk, arst_n, rsp_valid && slot_out != '0, ok && fire_mask == '0 && period_out == '0, "slot index on a non-allocate result")

	// A nonzero period or fire mask belongs to a successful get or scan alone.
	`MST_ASSERT_IMP(a_fields_exclusive, clk, arst_n, rsp_valid && (period_out != '0 || fire_mask != '0), ok && slot_out == '0 && (period_out == '0 || fire_mask == '0), "result fields mixed")

endmodule

bind multi_slot_tick_scheduler mst_checker u_mst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.fire_mask  (rsp.fire_mask),
	.slot_out   (rsp.slot_out),
	.period_out (rsp.period_out),
	.ok         (rsp.ok)
);
